[sv/bmp_pkg.sv]
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared constants and types of the binomial coefficient mod prime block.
// ----------------------------------------------------------------------------
package bmp_pkg;

  // field widths
  localparam int unsigned TopW    = 17;
  localparam int unsigned ChooseW = 18;
  localparam int unsigned ValueW  = 30;

  // default saturation bound for the upper argument
  localparam int unsigned MaxNDefault = 131071;

  // modulus and Fermat exponent
  localparam logic [ValueW-1:0] Prime   = 30'd998244353;
  localparam logic [ValueW-1:0] PrimeM2 = 30'd998244351;

  // Barrett reduction constants, mu = floor(2^60 / P) fits in 31 bits
  localparam longint unsigned BarrettMuL = (64'd1 << 60) / 64'd998244353;
  localparam logic [30:0]     BarrettMu  = 31'(BarrettMuL);
  localparam logic [31:0]     PrimeX1    = 32'd998244353;
  localparam logic [31:0]     PrimeX2    = 32'd1996488706;

  // request to the shared modular multiplier
  typedef struct packed {
    logic              start;
    logic [ValueW-1:0] a;
    logic [ValueW-1:0] b;
  } mm_req_t;

  // response of the shared modular multiplier
  typedef struct packed {
    logic              done;
    logic [ValueW-1:0] prod;
  } mm_rsp_t;

endpackage

[sv/bmp_if.sv]
// ----------------------------------------------------------------------------
// bmp_if
// Valid/ready channels of the binomial block: argument request and result.
// ----------------------------------------------------------------------------
interface bmp_in_if;
  logic                                valid;
  logic                                ready;
  logic        [bmp_pkg::TopW-1:0]     top;
  logic signed [bmp_pkg::ChooseW-1:0]  choose;

  modport source (output valid, output top, output choose, input ready);
  modport sink   (input valid, input top, input choose, output ready);
endinterface

interface bmp_out_if;
  logic                          valid;
  logic                          ready;
  logic [bmp_pkg::ValueW-1:0]    value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

[sv/bmp_modmul.sv]
// ----------------------------------------------------------------------------
// bmp_modmul
// Multi-cycle a*b mod P with Barrett reduction on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module bmp_modmul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bmp_pkg::mm_req_t req_i,
  output bmp_pkg::mm_rsp_t rsp_o
);

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhEst  = 2'd1;
  localparam logic [1:0] PhSub  = 2'd2;
  localparam logic [1:0] PhFix  = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [59:0] x_q;
  logic [63:0] t_q;
  logic        done_q;
  logic [29:0] res_q, res_d;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_out;
  logic [31:0] rem;

  // operand select for the single multiplier
  always_comb begin
    unique case (phase_q)
      PhIdle: begin
        mul_a = {2'b00, req_i.a};
        mul_b = {2'b00, req_i.b};
      end
      PhEst: begin
        mul_a = {1'b0, x_q[59:29]};
        mul_b = {1'b0, bmp_pkg::BarrettMu};
      end
      PhSub: begin
        mul_a = {1'b0, t_q[61:31]};
        mul_b = bmp_pkg::PrimeX1;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_out = 64'(mul_a) * 64'(mul_b);

  // remainder lies below 3P, two conditional subtracts finish it
  assign rem = x_q[31:0] - t_q[31:0];

  always_comb begin
    if (rem >= bmp_pkg::PrimeX2) begin
      res_d = 30'(rem - bmp_pkg::PrimeX2);
    end else if (rem >= bmp_pkg::PrimeX1) begin
      res_d = 30'(rem - bmp_pkg::PrimeX1);
    end else begin
      res_d = rem[29:0];
    end
  end

  // phase sequencing
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PhIdle:  if (req_i.start) phase_d = PhEst;
      PhEst:   phase_d = PhSub;
      PhSub:   phase_d = PhFix;
      default: phase_d = PhIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= (phase_q == PhFix);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (phase_q == PhIdle) x_q <= mul_out[59:0];
    if (phase_q == PhEst || phase_q == PhSub) t_q <= mul_out;
    if (phase_q == PhFix) res_q <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = res_q;

`ifndef SYNTHESIS
  // a new product is only requested while the unit is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> phase_q == PhIdle)
    else $error("modmul started while busy");

  // every delivered product is fully reduced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> res_q < bmp_pkg::Prime)
    else $error("modmul result not reduced");

  // completion is flagged in the cycle after the reduction phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(phase_q) == PhFix)
    else $error("modmul done without reduction");
`endif

endmodule

[sv/binomial_mod_prime.sv]
// ----------------------------------------------------------------------------
// binomial_mod_prime
// C(n,k) mod 998244353 computed by a small sequencer around one modmul unit.
// ----------------------------------------------------------------------------
// Each request carries n (top) and a signed k (choose) and returns one result.
// Negative k and k above n answer 0 without a modular product. Otherwise
// the block forms n-k+1..n and k! together in k steps of two modular
// products each, inverts k! by square-and-multiply with exponent P-2 and
// multiplies once more. Every product goes through the shared Barrett
// multiplier. A new request is taken once the previous result has been
// handed to the output register; that result waits there until taken.
module binomial_mod_prime #(
  parameter int unsigned MaxN = bmp_pkg::MaxNDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bmp_in_if.sink     item_i,
  bmp_out_if.source  result_o
);

  localparam int unsigned NBits = $clog2(MaxN + 1);
  localparam int unsigned IdxW  = (NBits > bmp_pkg::TopW) ? NBits : bmp_pkg::TopW;
  localparam int unsigned VW    = bmp_pkg::ValueW;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StNum    = 3'd1;
  localparam logic [2:0] StDen    = 3'd2;
  localparam logic [2:0] StInv    = 3'd3;
  localparam logic [2:0] StInvMul = 3'd4;
  localparam logic [2:0] StInvSqr = 3'd5;
  localparam logic [2:0] StFinal  = 3'd6;
  localparam logic [2:0] StDone   = 3'd7;

  logic [2:0]    state_q, state_d;
  logic          wait_q, wait_d;
  logic          out_valid_q, out_valid_d;
  logic [VW-1:0] value_q, value_d;
  logic [IdxW-1:0] k_q, k_d;
  logic [IdxW-1:0] low_q, low_d;
  logic [IdxW:0]   j_q, j_d;
  logic [VW-1:0] num_q, num_d;
  logic [VW-1:0] den_q, den_d;
  logic [VW-1:0] base_q, base_d;
  logic [VW-1:0] exp_q, exp_d;
  logic [VW-1:0] pres_q, pres_d;

  logic [IdxW-1:0] top_ext, n_in, k_in;
  logic [IdxW:0]   factor;

  bmp_pkg::mm_req_t mm_req;
  bmp_pkg::mm_rsp_t mm_rsp;

  bmp_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );

  // request decode with saturation of n
  assign top_ext = IdxW'(item_i.top);
  assign n_in    = (top_ext > IdxW'(MaxN)) ? IdxW'(MaxN) : top_ext;
  assign k_in    = IdxW'(item_i.choose[bmp_pkg::ChooseW-2:0]);
  assign factor  = {1'b0, low_q} + j_q;

  assign item_i.ready   = (state_q == StIdle);
  assign result_o.valid = out_valid_q;
  assign result_o.value = value_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    wait_d      = wait_q;
    out_valid_d = out_valid_q;
    value_d     = value_q;
    k_d         = k_q;
    low_d       = low_q;
    j_d         = j_q;
    num_d       = num_q;
    den_d       = den_q;
    base_d      = base_q;
    exp_d       = exp_q;
    pres_d      = pres_q;
    mm_req      = '0;

    // output register drains independently
    if (out_valid_q && result_o.ready) out_valid_d = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (item_i.valid) begin
          if (item_i.choose[bmp_pkg::ChooseW-1] || (k_in > n_in)) begin
            num_d   = '0;
            state_d = StDone;
          end else begin
            k_d     = k_in;
            low_d   = n_in - k_in;
            j_d     = (IdxW+1)'(1);
            num_d   = VW'(1);
            den_d   = VW'(1);
            state_d = StNum;
          end
        end
      end
      // numerator factor n-k+j
      StNum: begin
        if (!wait_q) begin
          if (j_q > {1'b0, k_q}) begin
            base_d  = den_q;
            exp_d   = bmp_pkg::PrimeM2;
            pres_d  = VW'(1);
            state_d = StInv;
          end else begin
            mm_req.start = 1'b1;
            mm_req.a     = num_q;
            mm_req.b     = VW'(factor);
            wait_d       = 1'b1;
          end
        end else if (mm_rsp.done) begin
          num_d   = mm_rsp.prod;
          wait_d  = 1'b0;
          state_d = StDen;
        end
      end
      // denominator factor j
      StDen: begin
        if (!wait_q) begin
          mm_req.start = 1'b1;
          mm_req.a     = den_q;
          mm_req.b     = VW'(j_q);
          wait_d       = 1'b1;
        end else if (mm_rsp.done) begin
          den_d   = mm_rsp.prod;
          j_d     = j_q + 1'b1;
          wait_d  = 1'b0;
          state_d = StNum;
        end
      end
      // square-and-multiply over the exponent bits
      StInv: begin
        if (exp_q == '0) begin
          state_d = StFinal;
        end else if (exp_q[0]) begin
          state_d = StInvMul;
        end else begin
          state_d = StInvSqr;
        end
      end
      StInvMul: begin
        if (!wait_q) begin
          mm_req.start = 1'b1;
          mm_req.a     = pres_q;
          mm_req.b     = base_q;
          wait_d       = 1'b1;
        end else if (mm_rsp.done) begin
          pres_d  = mm_rsp.prod;
          wait_d  = 1'b0;
          state_d = StInvSqr;
        end
      end
      StInvSqr: begin
        if (!wait_q) begin
          mm_req.start = 1'b1;
          mm_req.a     = base_q;
          mm_req.b     = base_q;
          wait_d       = 1'b1;
        end else if (mm_rsp.done) begin
          base_d  = mm_rsp.prod;
          exp_d   = exp_q >> 1;
          wait_d  = 1'b0;
          state_d = StInv;
        end
      end
      // numerator times inverse denominator
      StFinal: begin
        if (!wait_q) begin
          mm_req.start = 1'b1;
          mm_req.a     = num_q;
          mm_req.b     = pres_q;
          wait_d       = 1'b1;
        end else if (mm_rsp.done) begin
          num_d   = mm_rsp.prod;
          wait_d  = 1'b0;
          state_d = StDone;
        end
      end
      // hand over once the output register is free
      StDone: begin
        if (!out_valid_q || result_o.ready) begin
          value_d     = num_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wait_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wait_q      <= wait_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    k_q     <= k_d;
    low_q   <= low_d;
    j_q     <= j_d;
    num_q   <= num_d;
    den_q   <= den_d;
    base_q  <= base_d;
    exp_q   <= exp_d;
    pres_q  <= pres_d;
  end

`ifndef SYNTHESIS
  // the multiplier only answers a product that was asked for
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_rsp.done |-> wait_q)
    else $error("unexpected modmul response");

  // the step counter never runs past k+1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StNum || state_q == StDen) |-> j_q <= ({1'b0, k_q} + 1'b1))
    else $error("step counter overrun");

  // a presented result is always reduced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> value_q < bmp_pkg::Prime)
    else $error("result not reduced");
`endif

endmodule

[test/binomial_mod_prime_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_mod_prime_tb
// Sends (n, k) requests with random gaps and random result back-pressure, and
// checks every result against C(n,k) mod 998244353 computed alongside.
// ----------------------------------------------------------------------------
module binomial_mod_prime_tb;

  localparam int unsigned TopW          = bmp_pkg::TopW;
  localparam int unsigned ChooseW       = bmp_pkg::ChooseW;
  localparam int unsigned ValueW        = bmp_pkg::ValueW;
  localparam int unsigned WatchdogLimit = 200000;
  localparam int unsigned TailCycles    = 1000;
  localparam int unsigned TopMax        = (1 << TopW) - 1;
  localparam int unsigned ChooseMax     = (1 << (ChooseW - 1)) - 1;

  logic clk_i;
  logic rst_ni;

  bmp_in_if  in_if ();
  bmp_out_if out_if ();

  binomial_mod_prime dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (in_if),
    .result_o(out_if)
  );

  // expected coefficients, oldest first
  logic [ValueW-1:0] binom_expected[$];
  int unsigned       mismatches = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       src_gap_pct = 0;
  int unsigned       sink_stall_pct = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // a * b mod P
  function automatic longint unsigned mod_mul(longint unsigned a, longint unsigned b);
    return (a * b) % longint'(bmp_pkg::Prime);
  endfunction

  // C(n,k) mod P, falling product over k! inverted by Fermat
  function automatic logic [ValueW-1:0] binom_mod(logic [TopW-1:0] n,
                                                  logic signed [ChooseW-1:0] k);
    int              nv;
    int              kv;
    longint unsigned num;
    longint unsigned den;
    longint unsigned base;
    longint unsigned acc;
    longint unsigned ex;
    nv = int'(n);
    kv = int'(k);
    if (nv > int'(bmp_pkg::MaxNDefault)) nv = int'(bmp_pkg::MaxNDefault);
    if (kv < 0 || kv > nv) return '0;
    num = 1;
    den = 1;
    for (int i = 1; i <= kv; i++) begin
      num = mod_mul(num, longint'(nv - kv + i));
      den = mod_mul(den, longint'(i));
    end
    // den^(P-2)
    base = den;
    acc  = 1;
    ex   = longint'(bmp_pkg::PrimeM2);
    while (ex != 0) begin
      if (ex[0]) acc = mod_mul(acc, base);
      base = mod_mul(base, base);
      ex   = ex >> 1;
    end
    return ValueW'(mod_mul(num, acc));
  endfunction

  // result side: random back-pressure, check, watchdog
  always @(posedge clk_i) begin
    logic [ValueW-1:0] want;
    out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (binom_expected.size() == 0) begin
        $error("value: no request pending, got %0d", out_if.value);
        mismatches++;
      end else begin
        want = binom_expected.pop_front();
        if (out_if.value !== want) begin
          $error("value: expected %0d, got %0d", want, out_if.value);
          mismatches++;
        end
      end
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogLimit) begin
      $display("FAIL binomial_mod_prime");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request, with an optional random gap before it
  task automatic send_request(logic [TopW-1:0] n, logic signed [ChooseW-1:0] k);
    if ($urandom_range(99) < src_gap_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_gap_pct);
    end
    in_if.valid  <= 1'b1;
    in_if.top    <= n;
    in_if.choose <= k;
    do @(posedge clk_i); while (!in_if.ready);
    binom_expected.push_back(binom_mod(n, k));
  endtask

  // hold off until every pending result has come back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (binom_expected.size() != 0);
  endtask

  // empty product and the smallest nontrivial cases
  task automatic test_trivial_choose();
    send_request(0, 0);
    send_request(TopW'(TopMax), 0);
    send_request(1, 1);
    send_request(10, 10);
    send_request(TopW'(TopMax), 1);
    send_request(TopW'(TopMax), 2);
  endtask

  // negative k answers zero
  task automatic test_negative_choose();
    send_request(5, ChooseW'(-1));
    send_request(TopW'(TopMax), ChooseW'(-int'(ChooseMax) - 1));
    send_request(0, ChooseW'(-int'(ChooseMax) - 1));
    send_request(1234, ChooseW'(-2));
  endtask

  // k above n answers zero
  task automatic test_choose_above_top();
    send_request(0, 1);
    send_request(100, ChooseW'(ChooseMax));
    send_request(TopW'(TopMax - 1), ChooseW'(ChooseMax));
    send_request(7, 8);
  endtask

  // known values and the longer loops
  task automatic test_known_values();
    send_request(20, 10);
    send_request(TopW'(TopMax), 17);
    send_request(2000, 1000);
    send_request(TopW'(TopMax), 3000);
    send_request(65536, 33);
  endtask

  // random mix, mostly k within 0..n
  task automatic test_random_mix(int unsigned count);
    int unsigned       pick;
    int unsigned       nv;
    int unsigned       kv;
    logic signed [ChooseW-1:0] k;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        kv = $urandom_range(48);
        nv = $urandom_range(1) ? $urandom_range(kv + 200, kv) : $urandom_range(TopMax, kv);
        k  = ChooseW'(kv);
      end else if (pick < 80) begin
        nv = $urandom_range(TopMax - 1);
        k  = ChooseW'($urandom_range(ChooseMax, nv + 1));
      end else if (pick < 92) begin
        nv = $urandom_range(TopMax);
        k  = -ChooseW'($urandom_range(ChooseMax + 1, 1));
      end else begin
        kv = $urandom_range(600);
        nv = $urandom_range(1) ? kv : $urandom_range(TopMax, kv);
        k  = ChooseW'(kv);
      end
      send_request(TopW'(nv), k);
    end
  endtask

  // sequence of tests
  initial begin
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.top    <= '0;
    in_if.choose <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_gap_pct    = 28;
    sink_stall_pct = 84;
    test_trivial_choose();
    test_negative_choose();
    test_choose_above_top();
    test_known_values();
    drain_results();
    test_random_mix(27);
    drain_results();

    src_gap_pct    = 84;
    sink_stall_pct = 28;
    test_random_mix(27);
    drain_results();

    src_gap_pct    = 0;
    sink_stall_pct = 0;
    test_random_mix(27);
    drain_results();

    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS binomial_mod_prime");
    end else begin
      $display("FAIL binomial_mod_prime");
    end
    $finish;
  end

endmodule

[files.f]
sv/bmp_pkg.sv
sv/bmp_if.sv
sv/bmp_modmul.sv
sv/binomial_mod_prime.sv
test/binomial_mod_prime_tb.sv
